### hdl/tcch_pkg.sv
// Package for the three-channel coincidence histogram: sizes, register codes,
// beat and pipeline types, and the saturating increment.
// No dependencies; every other file of the block imports it.
package tcch_pkg;

   localparam int TIME_BITS  = 18;
   localparam int NUM_BINS   = 40;
   localparam int BIN_WIDTH  = 1800;

   localparam int REG_BITS   = 18;
   localparam int CNT_BITS   = 32;
   localparam int RIDX_BITS  = 6;
   localparam int FBIN_BITS  = 6;

   localparam int BIN_BITS   = $clog2(NUM_BINS + 1);
   localparam int BW_BITS    = $clog2(BIN_WIDTH + 1);
   localparam int CMP_BITS   = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;
   localparam int QW_BITS    = TIME_BITS + BW_BITS;

   // q0 = (d * RECIP_K) >> RECIP_SHIFT is d / BIN_WIDTH or one less
   localparam int RECIP_SHIFT = TIME_BITS + $clog2(BIN_WIDTH);
   localparam int RECIP_BITS  = TIME_BITS + 1;
   localparam int PROD_BITS   = TIME_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_K =
      RECIP_BITS'((64'd1 << RECIP_SHIFT) / BIN_WIDTH);

   // read index map, compared at a width that holds every code
   localparam int IDX_EXT_BITS = 8;
   localparam logic [IDX_EXT_BITS-1:0] IDX_OVERFLOW  = IDX_EXT_BITS'(NUM_BINS);
   localparam logic [IDX_EXT_BITS-1:0] IDX_TOT_AB    = IDX_EXT_BITS'(NUM_BINS + 1);
   localparam logic [IDX_EXT_BITS-1:0] IDX_TOT_AC    = IDX_EXT_BITS'(NUM_BINS + 2);
   localparam logic [IDX_EXT_BITS-1:0] IDX_TOT_BC    = IDX_EXT_BITS'(NUM_BINS + 3);
   localparam logic [IDX_EXT_BITS-1:0] IDX_TOT_ABC   = IDX_EXT_BITS'(NUM_BINS + 4);
   localparam logic [IDX_EXT_BITS-1:0] IDX_TOT_NONE  = IDX_EXT_BITS'(NUM_BINS + 5);

   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LOW     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_HIGH    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILL_MIN_DELAY = 2'd2;

   localparam logic [REG_BITS-1:0] WINDOW_LOW_RST     = 18'd8;
   localparam logic [REG_BITS-1:0] WINDOW_HIGH_RST    = 18'd16;
   localparam logic [REG_BITS-1:0] FILL_MIN_DELAY_RST = 18'd1600;

   typedef struct packed {
      logic                 cmd;
      logic                 a_present;
      logic [TIME_BITS-1:0] a_time;
      logic                 b_present;
      logic [TIME_BITS-1:0] b_time;
      logic                 c_present;
      logic [TIME_BITS-1:0] c_time;
      logic [RIDX_BITS-1:0] read_index;
   } req_payload_type;

   typedef struct packed {
      logic                 ab_hit;
      logic                 ac_hit;
      logic                 bc_hit;
      logic                 abc_hit;
      logic                 none_hit;
      logic                 filled;
      logic [FBIN_BITS-1:0] fill_bin;
      logic [CNT_BITS-1:0]  read_value;
   } rsp_payload_type;

   typedef struct packed {
      logic [REG_BITS-1:0] window_low;
      logic [REG_BITS-1:0] window_high;
      logic [REG_BITS-1:0] fill_min_delay;
   } cfg_type;

   // one item as it travels down the pipeline
   typedef struct packed {
      logic                 is_read;
      logic                 rd_mem;
      logic                 ab_hit;
      logic                 ac_hit;
      logic                 bc_hit;
      logic                 abc_hit;
      logic                 none_hit;
      logic                 fill;
      logic [TIME_BITS-1:0] dab;
      logic [BIN_BITS-1:0]  addr;
      logic [CNT_BITS-1:0]  value;
   } item_type;

   function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
      return (v == '1) ? v : v + CNT_BITS'(1);
   endfunction

endpackage

### hdl/tcch_classify.sv
// Input stage: registers the request beat, tests the three pairs against the
// window, keeps the five saturating totals and serves total reads.
// Depends on tcch_pkg.
module tcch_classify (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  tcch_pkg::req_payload_type in_data,
   input  tcch_pkg::cfg_type        cfg,
   output logic                     out_valid,
   input  logic                     out_ready,
   output tcch_pkg::item_type       out_item
);
   import tcch_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff;

   logic [CNT_BITS-1:0] tot_ab_ff, tot_ac_ff, tot_bc_ff, tot_abc_ff, tot_none_ff;
   logic [CNT_BITS-1:0] tot_ab_in, tot_ac_in, tot_bc_in, tot_abc_in, tot_none_in;

   logic [TIME_BITS-1:0]    d_ab, d_ac, d_bc;
   logic                    ab, ac, bc, abc, none_hit, fill, is_read, rd_mem, fire;
   logic [IDX_EXT_BITS-1:0] ridx_ext;
   logic [CNT_BITS-1:0]     tot_value;

   function automatic logic [TIME_BITS-1:0] abs_diff(input logic [TIME_BITS-1:0] x,
                                                     input logic [TIME_BITS-1:0] y);
      return (x >= y) ? x - y : y - x;
   endfunction

   function automatic logic in_win(input logic p1, input logic p2,
                                   input logic [TIME_BITS-1:0] d,
                                   input logic [REG_BITS-1:0] lo,
                                   input logic [REG_BITS-1:0] hi);
      return p1 && p2 && (CMP_BITS'(d) >= CMP_BITS'(lo)) && (CMP_BITS'(d) <= CMP_BITS'(hi));
   endfunction

   assign fire      = s1_valid_ff && out_ready;
   assign in_ready  = !s1_valid_ff || out_ready;
   assign out_valid = s1_valid_ff;

   always_comb begin
      is_read  = (s1_data_ff.cmd == CMD_READ);
      d_ab     = abs_diff(s1_data_ff.a_time, s1_data_ff.b_time);
      d_ac     = abs_diff(s1_data_ff.a_time, s1_data_ff.c_time);
      d_bc     = abs_diff(s1_data_ff.b_time, s1_data_ff.c_time);
      ab       = !is_read && in_win(s1_data_ff.a_present, s1_data_ff.b_present, d_ab,
                                    cfg.window_low, cfg.window_high);
      ac       = !is_read && in_win(s1_data_ff.a_present, s1_data_ff.c_present, d_ac,
                                    cfg.window_low, cfg.window_high);
      bc       = !is_read && in_win(s1_data_ff.b_present, s1_data_ff.c_present, d_bc,
                                    cfg.window_low, cfg.window_high);
      abc      = ab && ac;
      none_hit = !is_read && !ab && !ac && !bc;
      // A-C in window without the triple, B present and far enough from A
      fill     = ac && !ab && s1_data_ff.b_present &&
                 (CMP_BITS'(d_ab) >= CMP_BITS'(cfg.fill_min_delay));

      ridx_ext = IDX_EXT_BITS'(s1_data_ff.read_index);
      rd_mem   = is_read && (ridx_ext <= IDX_OVERFLOW);
      priority if (!is_read)                 tot_value = '0;
      else if (ridx_ext == IDX_TOT_AB)       tot_value = tot_ab_ff;
      else if (ridx_ext == IDX_TOT_AC)       tot_value = tot_ac_ff;
      else if (ridx_ext == IDX_TOT_BC)       tot_value = tot_bc_ff;
      else if (ridx_ext == IDX_TOT_ABC)      tot_value = tot_abc_ff;
      else if (ridx_ext == IDX_TOT_NONE)     tot_value = tot_none_ff;
      else                                   tot_value = '0;

      out_item.is_read  = is_read;
      out_item.rd_mem   = rd_mem;
      out_item.ab_hit   = ab;
      out_item.ac_hit   = ac;
      out_item.bc_hit   = bc;
      out_item.abc_hit  = abc;
      out_item.none_hit = none_hit;
      out_item.fill     = fill;
      out_item.dab      = d_ab;
      out_item.addr     = rd_mem ? BIN_BITS'(ridx_ext) : '0;
      out_item.value    = tot_value;
   end

   always_comb begin
      s1_valid_in = in_ready ? in_valid : s1_valid_ff;
      tot_ab_in   = (fire && ab)       ? sat_inc(tot_ab_ff)   : tot_ab_ff;
      tot_ac_in   = (fire && ac)       ? sat_inc(tot_ac_ff)   : tot_ac_ff;
      tot_bc_in   = (fire && bc)       ? sat_inc(tot_bc_ff)   : tot_bc_ff;
      tot_abc_in  = (fire && abc)      ? sat_inc(tot_abc_ff)  : tot_abc_ff;
      tot_none_in = (fire && none_hit) ? sat_inc(tot_none_ff) : tot_none_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         tot_ab_ff   <= '0;
         tot_ac_ff   <= '0;
         tot_bc_ff   <= '0;
         tot_abc_ff  <= '0;
         tot_none_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         tot_ab_ff   <= tot_ab_in;
         tot_ac_ff   <= tot_ac_in;
         tot_bc_ff   <= tot_bc_in;
         tot_abc_ff  <= tot_abc_in;
         tot_none_ff <= tot_none_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_data_ff <= in_data;
      end
   end

endmodule

### hdl/tcch_bin_div.sv
// Two-stage constant divider: turns the A-B delay into a histogram bin by a
// reciprocal multiply, one correction step and the overflow clamp.
// Depends on tcch_pkg.
module tcch_bin_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tcch_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output tcch_pkg::item_type out_item
);
   import tcch_pkg::*;

   logic                 s2_valid_ff, s2_valid_in, s3_valid_ff, s3_valid_in;
   item_type             s2_item_ff, s3_item_ff;
   logic [TIME_BITS-1:0] s3_q0_ff, q0_in;
   logic                 s2_ready, s3_ready;

   logic [PROD_BITS-1:0] prod;
   logic [TIME_BITS-1:0] qw, rem, quot;
   logic                 corr;
   logic [BIN_BITS-1:0]  bin;

   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign in_ready  = s2_ready;
   assign out_valid = s3_valid_ff;

   // stage 2: reciprocal multiply
   always_comb begin
      prod  = PROD_BITS'(s2_item_ff.dab) * PROD_BITS'(RECIP_K);
      q0_in = TIME_BITS'(prod >> RECIP_SHIFT);
   end

   // stage 3: correct by at most one, then clamp to the overflow bin
   always_comb begin
      qw   = TIME_BITS'(QW_BITS'(s3_q0_ff) * QW_BITS'(BIN_WIDTH));
      rem  = s3_item_ff.dab - qw;
      corr = QW_BITS'(rem) >= QW_BITS'(BIN_WIDTH);
      quot = s3_q0_ff + TIME_BITS'(corr);
      if (QW_BITS'(quot) >= QW_BITS'(NUM_BINS)) begin
         bin = BIN_BITS'(NUM_BINS);
      end else begin
         bin = BIN_BITS'(quot);
      end
      out_item = s3_item_ff;
      if (!s3_item_ff.is_read) begin
         out_item.addr = bin;
      end
   end

   always_comb begin
      s2_valid_in = s2_ready ? in_valid : s2_valid_ff;
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s2_ready) begin
         s2_item_ff <= in_item;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_item_ff <= s2_item_ff;
         s3_q0_ff   <= q0_in;
      end
   end

   // the reciprocal estimate is never more than one below the true quotient
   a_recip_error: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s3_item_ff.is_read |-> QW_BITS'(rem) < QW_BITS'(2 * BIN_WIDTH))
      else $error("bin divider estimate off by more than one");

endmodule

### hdl/tcch_hist.sv
// Histogram memory with its read-modify-write stage and the response register.
// Per-entry valid bits stand in for clearing; a last-write register forwards.
// Depends on tcch_pkg.
module tcch_hist (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  tcch_pkg::item_type        in_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tcch_pkg::rsp_payload_type rsp_data
);
   import tcch_pkg::*;

   logic [CNT_BITS-1:0] mem [NUM_BINS+1];
   logic [NUM_BINS:0]   hvalid_ff, hvalid_in;
   logic [CNT_BITS-1:0] rd_data_ff;

   logic                s4_valid_ff, s4_valid_in;
   item_type            s4_item_ff;
   logic                s4_adv, rd_en, wr_en;

   logic                lw_valid_ff, lw_valid_in;
   logic [BIN_BITS-1:0] lw_addr_ff;
   logic [CNT_BITS-1:0] lw_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic [CNT_BITS-1:0] cur_value, wr_data;

   assign s4_adv    = s4_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign in_ready  = !s4_valid_ff || s4_adv;
   assign rd_en     = in_valid && in_ready;
   assign wr_en     = s4_adv && s4_item_ff.fill;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // take the newest write when it hit the same entry as this read
      cur_value = (lw_valid_ff && (lw_addr_ff == s4_item_ff.addr)) ? lw_data_ff : rd_data_ff;
      wr_data   = sat_inc(cur_value);

      rsp_data_in.ab_hit     = s4_item_ff.ab_hit;
      rsp_data_in.ac_hit     = s4_item_ff.ac_hit;
      rsp_data_in.bc_hit     = s4_item_ff.bc_hit;
      rsp_data_in.abc_hit    = s4_item_ff.abc_hit;
      rsp_data_in.none_hit   = s4_item_ff.none_hit;
      rsp_data_in.filled     = s4_item_ff.fill;
      rsp_data_in.fill_bin   = s4_item_ff.fill ? FBIN_BITS'(s4_item_ff.addr) : '0;
      rsp_data_in.read_value = s4_item_ff.rd_mem ? cur_value : s4_item_ff.value;

      s4_valid_in  = in_ready ? in_valid : s4_valid_ff;
      rsp_valid_in = s4_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      lw_valid_in  = lw_valid_ff || wr_en;
      hvalid_in    = hvalid_ff;
      if (wr_en) begin
         hvalid_in[s4_item_ff.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hvalid_ff[in_item.addr] ? mem[in_item.addr] : '0;
      end
      if (wr_en) begin
         mem[s4_item_ff.addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvalid_ff    <= '0;
         s4_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hvalid_ff    <= hvalid_in;
         s4_valid_ff  <= s4_valid_in;
         lw_valid_ff  <= lw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s4_item_ff <= in_item;
      end
      if (wr_en) begin
         lw_addr_ff <= s4_item_ff.addr;
         lw_data_ff <= wr_data;
      end
      if (s4_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s4_item_ff.addr <= BIN_BITS'(NUM_BINS))
      else $error("histogram write beyond the overflow bin");

   a_wr_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> hvalid_ff[$past(s4_item_ff.addr)])
      else $error("histogram entry written but not marked valid");

   a_fill_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.filled |-> rsp_data_ff.ac_hit && !rsp_data_ff.ab_hit)
      else $error("fill reported without A-C alone in window");

endmodule

### hdl/three_channel_coincidence_histogram.sv
// Three-channel coincidence trigger with an A-B delay histogram of 41 bins.
// Takes one request beat per clock while the response side does not stall, and
// returns one response beat for each, in order, via stages s1 to s4 and rsp.
// The rate is set by the histogram read-modify-write: one memory read and one
// write per cycle, with a last-write register forwarding back-to-back hits on
// the same bin. Totals and bins saturate at all ones. Bins are cleared at
// reset by per-entry valid bits, so there is no clearing pass and the block
// takes beats from the first cycle after reset. Write the csr_ registers only
// while no request is in flight.
module three_channel_coincidence_histogram (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  tcch_pkg::req_payload_type              req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output tcch_pkg::rsp_payload_type              rsp_data,
   input  logic                                   csr_we,
   input  logic [tcch_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [tcch_pkg::REG_BITS-1:0]          csr_wdata
);
   import tcch_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cls_valid, cls_ready, div_valid, div_ready;
   item_type cls_item, div_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LOW:     cfg_in.window_low     = csr_wdata;
            CSR_WINDOW_HIGH:    cfg_in.window_high    = csr_wdata;
            CSR_FILL_MIN_DELAY: cfg_in.fill_min_delay = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_low     <= WINDOW_LOW_RST;
         cfg_ff.window_high    <= WINDOW_HIGH_RST;
         cfg_ff.fill_min_delay <= FILL_MIN_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcch_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (cls_valid),
      .out_ready (cls_ready),
      .out_item  (cls_item)
   );

   tcch_bin_div u_bin_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_ready  (cls_ready),
      .in_item   (cls_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item)
   );

   tcch_hist u_hist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_item   (div_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
